@@ rtl/mba_pkg.sv @@
// Shared constants, types and codes for the mosaic block averaging design.
package mba_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_TILE     = 256;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int POS_W      = 12;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int OFF_W      = $clog2(MAX_TILE);
    localparam int DIM_W      = 13;
    localparam int TILE_W     = 9;
    localparam int CH_W       = 8;
    localparam int SUM_W      = 24;
    localparam int CNT_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int STEP_W     = $clog2(SUM_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_TILE_SIZE    = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FINISH
    } div_state_t;

    // Active geometry, already clamped to the legal ranges.
    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [TILE_W-1:0] tile;
    } cfg_t;

    // A finished tile handed from the accumulator to the divider.
    typedef struct packed {
        logic [POS_W-1:0] tile_col;
        logic [POS_W-1:0] tile_row;
        logic [CNT_W-1:0] pixels;
        logic [SUM_W-1:0] sum_blue;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_red;
        logic             frame_done;
    } job_t;

    typedef struct packed {
        logic [POS_W-1:0] tile_col;
        logic [POS_W-1:0] tile_row;
        logic [CH_W-1:0]  mean_blue;
        logic [CH_W-1:0]  mean_green;
        logic [CH_W-1:0]  mean_red;
        logic [CNT_W-1:0] tile_pixels;
        logic             frame_done;
    } result_t;

endpackage

@@ rtl/mba_if.sv @@
// Valid/ready channel interfaces for pixel beats and tile result beats.
interface mba_pix_if;
    logic                        valid;
    logic                        ready;
    logic                        frame_start;
    logic [mba_pkg::CH_W-1:0]    pix_blue;
    logic [mba_pkg::CH_W-1:0]    pix_green;
    logic [mba_pkg::CH_W-1:0]    pix_red;

    modport source (output valid, frame_start, pix_blue, pix_green, pix_red, input ready);
    modport sink   (input valid, frame_start, pix_blue, pix_green, pix_red, output ready);
endinterface

interface mba_tile_if;
    logic                        valid;
    logic                        ready;
    logic [mba_pkg::POS_W-1:0]   tile_col;
    logic [mba_pkg::POS_W-1:0]   tile_row;
    logic [mba_pkg::CH_W-1:0]    mean_blue;
    logic [mba_pkg::CH_W-1:0]    mean_green;
    logic [mba_pkg::CH_W-1:0]    mean_red;
    logic [mba_pkg::CNT_W-1:0]   tile_pixels;
    logic                        frame_done;

    modport source (output valid, tile_col, tile_row, mean_blue, mean_green, mean_red,
                    tile_pixels, frame_done, input ready);
    modport sink   (input valid, tile_col, tile_row, mean_blue, mean_green, mean_red,
                    tile_pixels, frame_done, output ready);
endinterface

@@ rtl/mba_acc.sv @@
// Raster position tracking and per-tile-column sum memory with read-modify-write.
module mba_acc
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mba_pkg::cfg_t             cfg,
    input  logic                      restart,
    input  logic                      beat,
    input  logic                      frame_start,
    input  logic [mba_pkg::CH_W-1:0]  pix_blue,
    input  logic [mba_pkg::CH_W-1:0]  pix_green,
    input  logic [mba_pkg::CH_W-1:0]  pix_red,
    output logic                      job_valid,
    output mba_pkg::job_t             job
);

    localparam int WORD_W = 3 * mba_pkg::SUM_W;
    localparam int SW     = mba_pkg::SUM_W;

    logic [WORD_W-1:0] mem [mba_pkg::MAX_WIDTH];

    logic [mba_pkg::POS_W-1:0] pixel_x_reg, pixel_y_reg, tcol_reg, trow_reg;
    logic [mba_pkg::OFF_W-1:0] off_x_reg, off_y_reg;
    logic [mba_pkg::POS_W-1:0] pixel_x_next, pixel_y_next, tcol_next, trow_next;
    logic [mba_pkg::OFF_W-1:0] off_x_next, off_y_next;

    logic [mba_pkg::POS_W-1:0] cur_x, cur_y, cur_tcol, cur_trow;
    logic [mba_pkg::OFF_W-1:0] cur_ox, cur_oy;
    logic [mba_pkg::TILE_W-1:0] ox1, oy1;
    logic [2*mba_pkg::TILE_W-1:0] prod;
    logic row_end, col_end, tile_right, tile_bottom, fresh;

    // Write-back stage registers.
    logic                       s1_valid_reg;
    logic                       s1_emit_reg;
    logic                       s1_fresh_reg;
    logic                       s1_fwd_reg;
    logic                       s1_done_reg;
    logic [mba_pkg::COL_W-1:0]  s1_col_reg;
    logic [mba_pkg::POS_W-1:0]  s1_trow_reg;
    logic [mba_pkg::CNT_W-1:0]  s1_n_reg;
    logic [3*mba_pkg::CH_W-1:0] s1_pix_reg;
    logic [WORD_W-1:0]          rd_word_reg;
    logic [WORD_W-1:0]          prev_sum_reg;
    logic [WORD_W-1:0]          base_word, sum_word;

    always_comb
    begin
        cur_x    = frame_start ? '0 : pixel_x_reg;
        cur_y    = frame_start ? '0 : pixel_y_reg;
        cur_ox   = frame_start ? '0 : off_x_reg;
        cur_oy   = frame_start ? '0 : off_y_reg;
        cur_tcol = frame_start ? '0 : tcol_reg;
        cur_trow = frame_start ? '0 : trow_reg;

        ox1  = {1'b0, cur_ox} + mba_pkg::TILE_W'(1);
        oy1  = {1'b0, cur_oy} + mba_pkg::TILE_W'(1);
        prod = ox1 * oy1;

        row_end     = ({1'b0, cur_x} + mba_pkg::DIM_W'(1)) >= cfg.width;
        col_end     = ({1'b0, cur_y} + mba_pkg::DIM_W'(1)) >= cfg.height;
        tile_right  = (ox1 >= cfg.tile) || row_end;
        tile_bottom = (oy1 >= cfg.tile) || col_end;
        fresh       = (cur_ox == '0) && (cur_oy == '0);
    end

    always_comb
    begin
        pixel_x_next = cur_x + mba_pkg::POS_W'(1);
        pixel_y_next = cur_y;
        off_x_next   = tile_right ? '0 : cur_ox + mba_pkg::OFF_W'(1);
        off_y_next   = cur_oy;
        tcol_next    = tile_right ? cur_tcol + mba_pkg::POS_W'(1) : cur_tcol;
        trow_next    = cur_trow;
        if (row_end)
        begin
            pixel_x_next = '0;
            off_x_next   = '0;
            tcol_next    = '0;
            pixel_y_next = cur_y + mba_pkg::POS_W'(1);
            if (tile_bottom)
            begin
                off_y_next = '0;
                trow_next  = cur_trow + mba_pkg::POS_W'(1);
            end
            else
            begin
                off_y_next = cur_oy + mba_pkg::OFF_W'(1);
            end
            if (col_end)
            begin
                pixel_y_next = '0;
                off_y_next   = '0;
                trow_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_x_reg  <= '0;
            pixel_y_reg  <= '0;
            off_x_reg    <= '0;
            off_y_reg    <= '0;
            tcol_reg     <= '0;
            trow_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= beat;
            if (restart)
            begin
                pixel_x_reg <= '0;
                pixel_y_reg <= '0;
                off_x_reg   <= '0;
                off_y_reg   <= '0;
                tcol_reg    <= '0;
                trow_reg    <= '0;
            end
            else if (beat)
            begin
                pixel_x_reg <= pixel_x_next;
                pixel_y_reg <= pixel_y_next;
                off_x_reg   <= off_x_next;
                off_y_reg   <= off_y_next;
                tcol_reg    <= tcol_next;
                trow_reg    <= trow_next;
            end
        end
    end

    // Stage payload; the forward flag marks a read that races the pending write.
    always_ff @(posedge clk)
    begin
        if (beat)
        begin
            s1_emit_reg  <= tile_right && tile_bottom;
            s1_fresh_reg <= fresh;
            s1_fwd_reg   <= s1_valid_reg && (s1_col_reg == cur_tcol);
            s1_done_reg  <= row_end && col_end;
            s1_col_reg   <= cur_tcol;
            s1_trow_reg  <= cur_trow;
            s1_n_reg     <= prod[mba_pkg::CNT_W-1:0];
            s1_pix_reg   <= {pix_blue, pix_green, pix_red};
        end
        if (s1_valid_reg)
        begin
            prev_sum_reg <= sum_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            mem[s1_col_reg] <= sum_word;
        end
        if (beat)
        begin
            rd_word_reg <= mem[cur_tcol];
        end
    end

    always_comb
    begin
        if (s1_fresh_reg)
        begin
            base_word = '0;
        end
        else if (s1_fwd_reg)
        begin
            base_word = prev_sum_reg;
        end
        else
        begin
            base_word = rd_word_reg;
        end
        sum_word[3*SW-1:2*SW] = base_word[3*SW-1:2*SW]
                              + SW'(s1_pix_reg[3*mba_pkg::CH_W-1:2*mba_pkg::CH_W]);
        sum_word[2*SW-1:SW]   = base_word[2*SW-1:SW]
                              + SW'(s1_pix_reg[2*mba_pkg::CH_W-1:mba_pkg::CH_W]);
        sum_word[SW-1:0]      = base_word[SW-1:0]
                              + SW'(s1_pix_reg[mba_pkg::CH_W-1:0]);
    end

    assign job_valid      = s1_valid_reg && s1_emit_reg;
    assign job.tile_col   = s1_col_reg;
    assign job.tile_row   = s1_trow_reg;
    assign job.pixels     = s1_n_reg;
    assign job.sum_blue   = sum_word[3*SW-1:2*SW];
    assign job.sum_green  = sum_word[2*SW-1:SW];
    assign job.sum_red    = sum_word[SW-1:0];
    assign job.frame_done = s1_done_reg;

endmodule

@@ rtl/mba_div.sv @@
// Three-lane bit-serial divider with round-half-even and the result output register.
module mba_div
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  mba_pkg::job_t    job,
    input  logic             out_ready,
    output logic             busy,
    output logic             out_valid,
    output mba_pkg::result_t result
);

    localparam int SW = mba_pkg::SUM_W;
    localparam int NW = mba_pkg::CNT_W;

    mba_pkg::div_state_t state_reg, state_next;
    logic [mba_pkg::STEP_W-1:0] step_reg;
    logic [SW-1:0] dq_reg   [3];
    logic [NW-1:0] rem_reg  [3];
    logic [SW-1:0] dq_next  [3];
    logic [NW-1:0] rem_next [3];
    logic [mba_pkg::CH_W-1:0] mean [3];
    logic [NW-1:0] n_reg;
    logic [mba_pkg::POS_W-1:0] col_reg, row_reg;
    logic done_reg;
    logic out_valid_reg;
    mba_pkg::result_t res_reg;
    logic load_job, do_step, load_out, out_free;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [NW:0] trial;
            logic [NW:0] twice;
            logic [SW:0] qr;
            logic        ge;
            logic        up;
            trial       = {rem_reg[i], dq_reg[i][SW-1]};
            ge          = trial >= {1'b0, n_reg};
            rem_next[i] = ge ? NW'(trial - {1'b0, n_reg}) : trial[NW-1:0];
            dq_next[i]  = {dq_reg[i][SW-2:0], ge};
            twice       = {rem_reg[i], 1'b0};
            up          = (twice > {1'b0, n_reg})
                       || ((twice == {1'b0, n_reg}) && dq_reg[i][0]);
            qr          = {1'b0, dq_reg[i]} + (SW + 1)'(up);
            mean[i]     = (qr > (SW + 1)'(255)) ? 8'hFF : qr[mba_pkg::CH_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mba_pkg::DIV_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = mba_pkg::DIV_RUN;
                end
            end
            mba_pkg::DIV_RUN:
            begin
                if (step_reg == mba_pkg::STEP_W'(SW - 1))
                begin
                    state_next = mba_pkg::DIV_FINISH;
                end
            end
            mba_pkg::DIV_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mba_pkg::DIV_IDLE;
                end
            end
            default:
            begin
                state_next = mba_pkg::DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load_job = 1'b0;
        do_step  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            mba_pkg::DIV_IDLE:   load_job = job_valid;
            mba_pkg::DIV_RUN:    do_step  = 1'b1;
            mba_pkg::DIV_FINISH: load_out = out_free;
            default:             load_job = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mba_pkg::DIV_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_job)
            begin
                step_reg <= '0;
            end
            else if (do_step)
            begin
                step_reg <= step_reg + mba_pkg::STEP_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_job)
        begin
            dq_reg[0]  <= job.sum_blue;
            dq_reg[1]  <= job.sum_green;
            dq_reg[2]  <= job.sum_red;
            rem_reg[0] <= '0;
            rem_reg[1] <= '0;
            rem_reg[2] <= '0;
            n_reg      <= job.pixels;
            col_reg    <= job.tile_col;
            row_reg    <= job.tile_row;
            done_reg   <= job.frame_done;
        end
        else if (do_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dq_reg[i]  <= dq_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
        if (load_out)
        begin
            res_reg.tile_col    <= col_reg;
            res_reg.tile_row    <= row_reg;
            res_reg.mean_blue   <= mean[0];
            res_reg.mean_green  <= mean[1];
            res_reg.mean_red    <= mean[2];
            res_reg.tile_pixels <= n_reg;
            res_reg.frame_done  <= done_reg;
        end
    end

    assign busy      = (state_reg != mba_pkg::DIV_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

@@ rtl/mosaic_block_average.sv @@
// Top level of the mosaic block averager: configuration registers, handshakes, submodules.
//
// Pixels enter on the pix channel in raster order, one beat per pixel, with
// frame_start marking the first pixel of a frame. Each channel is summed into
// a per-tile-column entry of a 4096-deep sum memory (read, add, write back).
// When the last pixel of a tile is accepted, the tile channel later carries one
// beat with the tile position, clipped pixel count, rounded channel means and
// a flag for the last tile of the frame.
// Throughput: one pixel per cycle while no tile finishes. The mean is found by
// a shared bit-serial divider, one quotient bit per cycle for all three
// channels, so a pixel that closes a tile blocks input until the divider is idle.
// The result sits in an output register; the divider may start the next tile
// while it waits, and if the receiver stalls, the divider holds its finished
// tile and input stays blocked until the register is freed.
// Reset returns the geometry to 640 x 480 with 8-pixel tiles and clears all
// position counters. No memory clearing pass is needed: the first pixel of
// every tile overwrites its column entry. A configuration write to a known
// register also restarts the frame position.
module mosaic_block_average
(
    input  logic                            clk,
    input  logic                            rst_n,
    mba_pix_if.sink                         pix,
    mba_tile_if.source                      tile,
    input  logic                            cfg_we,
    input  logic [mba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mba_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mba_pkg::cfg_t    cfg_reg;
    mba_pkg::job_t    job;
    mba_pkg::result_t result;
    logic             restart;
    logic             beat;
    logic             job_valid;
    logic             div_busy;

    // Clamp a dimension to 1..limit; zero means one.
    function automatic logic [mba_pkg::DIM_W-1:0] clamp_dim(
        input logic [mba_pkg::DIM_W-1:0] v,
        input logic [mba_pkg::DIM_W-1:0] limit
    );
        logic [mba_pkg::DIM_W-1:0] r;
        if (v == '0)
        begin
            r = mba_pkg::DIM_W'(1);
        end
        else if (v > limit)
        begin
            r = limit;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [mba_pkg::TILE_W-1:0] clamp_tile(
        input logic [mba_pkg::TILE_W-1:0] v
    );
        logic [mba_pkg::TILE_W-1:0] r;
        if (v == '0)
        begin
            r = mba_pkg::TILE_W'(1);
        end
        else if (v > mba_pkg::TILE_W'(mba_pkg::MAX_TILE))
        begin
            r = mba_pkg::TILE_W'(mba_pkg::MAX_TILE);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    always_comb
    begin
        case (mba_pkg::cfg_index_t'(cfg_index))
            mba_pkg::CFG_IMAGE_WIDTH,
            mba_pkg::CFG_IMAGE_HEIGHT,
            mba_pkg::CFG_TILE_SIZE: restart = cfg_we;
            default:                restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= mba_pkg::DIM_W'(640);
            cfg_reg.height <= mba_pkg::DIM_W'(480);
            cfg_reg.tile   <= mba_pkg::TILE_W'(8);
        end
        else if (cfg_we)
        begin
            case (mba_pkg::cfg_index_t'(cfg_index))
                mba_pkg::CFG_IMAGE_WIDTH:
                    cfg_reg.width  <= clamp_dim(cfg_data,
                                                mba_pkg::DIM_W'(mba_pkg::MAX_WIDTH));
                mba_pkg::CFG_IMAGE_HEIGHT:
                    cfg_reg.height <= clamp_dim(cfg_data,
                                                mba_pkg::DIM_W'(mba_pkg::HEIGHT_LIMIT));
                mba_pkg::CFG_TILE_SIZE:
                    cfg_reg.tile   <= clamp_tile(cfg_data[mba_pkg::TILE_W-1:0]);
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A pixel that may close a tile is taken only when the divider can take
    // its job right behind the write-back stage.
    assign pix.ready = !div_busy && !job_valid;
    assign beat      = pix.valid && pix.ready;

    mba_acc u_acc
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .restart     (restart),
        .beat        (beat),
        .frame_start (pix.frame_start),
        .pix_blue    (pix.pix_blue),
        .pix_green   (pix.pix_green),
        .pix_red     (pix.pix_red),
        .job_valid   (job_valid),
        .job         (job)
    );

    mba_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .out_ready (tile.ready),
        .busy      (div_busy),
        .out_valid (tile.valid),
        .result    (result)
    );

    assign tile.tile_col    = result.tile_col;
    assign tile.tile_row    = result.tile_row;
    assign tile.mean_blue   = result.mean_blue;
    assign tile.mean_green  = result.mean_green;
    assign tile.mean_red    = result.mean_red;
    assign tile.tile_pixels = result.tile_pixels;
    assign tile.frame_done  = result.frame_done;

endmodule
